[rtl/skd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skd_pkg: shared types and constants of the sidechain kick step detector
// Fixed-point formats, register indexes and the result item layout.
// ----------------------------------------------------------------------------
package skd_pkg;

  localparam int EnvFracBits = 15;
  localparam int EnvW        = 31;
  localparam int PeakW       = 16;
  localparam int MaskW       = 16;
  localparam int BarBits     = 18;
  localparam int BarLenLog2  = 2;   // four quarter notes per bar
  localparam int CoefW       = 15;
  localparam int ThreshW     = 16;
  localparam int CfgAddrW    = 2;
  localparam int CfgDataW    = 16;
  localparam int CalcW       = 48;

  localparam logic [PeakW-1:0] PeakMax = 16'd32768;
  localparam logic [EnvW-1:0]  EnvMax  = 31'h4000_0000;

  localparam logic [CoefW-1:0]   AttackReset    = 15'd32494;
  localparam logic [CoefW-1:0]   ReleaseReset   = 15'd32759;
  localparam logic [ThreshW-1:0] ThresholdReset = 16'd16384;

  typedef enum logic [CfgAddrW-1:0] {
    CfgAttack    = 2'd0,
    CfgRelease   = 2'd1,
    CfgThreshold = 2'd2
  } cfg_reg_e;

  // result item, kick_mask in the lowest bits
  typedef struct packed {
    logic             kick_onset;
    logic             kick_present;
    logic [PeakW-1:0] envelope_level;
    logic [MaskW-1:0] kick_mask;
  } out_item_t;

endpackage

[rtl/sidechain_kick_step_detector.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidechain_kick_step_detector: block peak envelope and kick step mask
// Tracks per-block peak magnitude, updates a Q16.15 envelope on each block
// end, flags kick onsets and marks them in a 16-step bar mask.
// ----------------------------------------------------------------------------
// Takes one sample item per clock cycle while s_axis_tready is high. Each item
// passes an input register, where magnitude, bar index and step are already
// formed, and the combinational envelope logic into the result register.
// The envelope update (one 15 x 32 bit multiply, rounding and clamp) lies
// wholly between these two registers, so block ends may follow each other
// back to back. Items that are not block ends produce no result. While a
// result waits on m_axis_tready, samples keep flowing; only a further block
// end holds the input.
module sidechain_kick_step_detector #(
  parameter int SAMPLE_BITS        = 16,
  parameter int POSITION_FRAC_BITS = 12,
  parameter int STEPS_PER_BAR      = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // slave side
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // tdata: sample, position
  input  logic [((SAMPLE_BITS+32+7)/8)*8-1:0]   s_axis_tdata,
  input  logic                                  s_axis_tlast,   // block_end
  input  logic                                  s_axis_tuser,   // position_valid
  // master side
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // tdata: kick_mask, envelope_level, kick_present, kick_onset
  output logic [39:0]                           m_axis_tdata,
  // configuration
  input  logic                                  cfg_we_i,
  input  logic [skd_pkg::CfgAddrW-1:0]          cfg_addr_i,
  input  logic [skd_pkg::CfgDataW-1:0]          cfg_wdata_i
);

  localparam int ExtW     = (SAMPLE_BITS + 1 > 17) ? SAMPLE_BITS + 1 : 17;
  localparam int BarShift = POSITION_FRAC_BITS + skd_pkg::BarLenLog2;
  localparam int StepW    = (STEPS_PER_BAR > 1) ? $clog2(STEPS_PER_BAR) : 1;
  localparam int ProdW    = BarShift + StepW + 2;
  localparam int OutW     = $bits(skd_pkg::out_item_t);

  // configuration registers
  logic [skd_pkg::CoefW-1:0]   attack_q, release_q;
  logic [skd_pkg::ThreshW-1:0] thresh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q  <= skd_pkg::AttackReset;
      release_q <= skd_pkg::ReleaseReset;
      thresh_q  <= skd_pkg::ThresholdReset;
    end else if (cfg_we_i) begin
      unique case (skd_pkg::cfg_reg_e'(cfg_addr_i))
        skd_pkg::CfgAttack:    attack_q  <= cfg_wdata_i[skd_pkg::CoefW-1:0];
        skd_pkg::CfgRelease:   release_q <= cfg_wdata_i[skd_pkg::CoefW-1:0];
        skd_pkg::CfgThreshold: thresh_q  <= cfg_wdata_i[skd_pkg::ThreshW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- input stage: magnitude, bar and step ----------------
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic signed [31:0]            in_pos;
  logic signed [ExtW-1:0]        s_ext;
  logic [ExtW-1:0]               abs_ext;
  logic [skd_pkg::PeakW-1:0]     in_mag;
  logic signed [31:0]            bar_full;
  logic [BarShift-1:0]           pos_in_bar;
  logic [ProdW-1:0]              step_prod;
  logic [StepW-1:0]              in_step;

  assign in_sample  = s_axis_tdata[SAMPLE_BITS-1:0];
  assign in_pos     = s_axis_tdata[SAMPLE_BITS +: 32];
  assign s_ext      = ExtW'(in_sample);
  assign abs_ext    = s_ext[ExtW-1] ? ExtW'(-s_ext) : ExtW'(s_ext);
  assign in_mag     = (abs_ext > ExtW'(skd_pkg::PeakMax)) ? skd_pkg::PeakMax
                                                          : abs_ext[skd_pkg::PeakW-1:0];
  assign bar_full   = in_pos >>> BarShift;
  assign pos_in_bar = in_pos[BarShift-1:0];
  assign step_prod  = ProdW'(pos_in_bar) * ProdW'(STEPS_PER_BAR);
  assign in_step    = step_prod[BarShift +: StepW];

  logic                        s1_valid_q, s1_last_q, s1_posv_q;
  logic [skd_pkg::PeakW-1:0]   s1_mag_q;
  logic [skd_pkg::BarBits-1:0] s1_bar_q;
  logic [StepW-1:0]            s1_step_q;
  logic                        s1_adv, s1_fire, out_load;
  logic                        out_valid_q;

  assign s1_adv        = !(s1_valid_q && s1_last_q && out_valid_q && !m_axis_tready);
  assign s1_fire       = s1_valid_q && s1_adv;
  assign out_load      = s1_fire && s1_last_q;
  assign s_axis_tready = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s1_mag_q  <= in_mag;
      s1_last_q <= s_axis_tlast;
      s1_posv_q <= s_axis_tuser;
      s1_bar_q  <= bar_full[skd_pkg::BarBits-1:0];
      s1_step_q <= in_step;
    end
  end

  // ---------------- envelope and mask stage ----------------
  logic [skd_pkg::PeakW-1:0]   peak_q, peak_d, peak_new;
  logic [skd_pkg::EnvW-1:0]    env_q, env_d, env_new;
  logic                        prev_kick_q, prev_kick_d;
  logic [skd_pkg::BarBits-1:0] last_bar_q, last_bar_d;
  logic                        have_bar_q, have_bar_d;
  logic [skd_pkg::MaskW-1:0]   mask_q, mask_d, mask_new;

  logic signed [skd_pkg::CalcW-1:0] pk48, env48, diff48, prod48, round48, sh48, raw48;
  logic [skd_pkg::CoefW-1:0]        coef_sel;
  logic                             kick_now, onset;
  skd_pkg::out_item_t               out_d, out_q;

  always_comb begin
    peak_new = (s1_mag_q > peak_q) ? s1_mag_q : peak_q;
    pk48     = skd_pkg::CalcW'(peak_new) <<< skd_pkg::EnvFracBits;
    env48    = skd_pkg::CalcW'(env_q);
    coef_sel = (pk48 > env48) ? attack_q : release_q;
    diff48   = env48 - pk48;
    prod48   = $signed(skd_pkg::CalcW'(coef_sel)) * diff48;
    round48  = prod48 + (skd_pkg::CalcW'(1) <<< (skd_pkg::EnvFracBits - 1));
    sh48     = round48 >>> skd_pkg::EnvFracBits;
    raw48    = pk48 + sh48;
    if (raw48 < 0) begin
      env_new = '0;
    end else if (raw48 > skd_pkg::CalcW'(skd_pkg::EnvMax)) begin
      env_new = skd_pkg::EnvMax;
    end else begin
      env_new = raw48[skd_pkg::EnvW-1:0];
    end
    kick_now = env_new > {thresh_q, {skd_pkg::EnvFracBits{1'b0}}};
    onset    = kick_now && !prev_kick_q;

    mask_new   = mask_q;
    last_bar_d = last_bar_q;
    have_bar_d = have_bar_q;
    if (s1_posv_q) begin
      if (have_bar_q && (s1_bar_q != last_bar_q)) begin
        mask_new = '0;
      end
      if (onset && (int'(s1_step_q) < skd_pkg::MaskW)) begin
        mask_new = mask_new | (skd_pkg::MaskW'(1) << s1_step_q);
      end
      last_bar_d = s1_bar_q;
      have_bar_d = 1'b1;
    end

    out_d.kick_mask      = mask_new;
    out_d.envelope_level = env_new[skd_pkg::EnvW-1 -: skd_pkg::PeakW];
    out_d.kick_present   = kick_now;
    out_d.kick_onset     = onset;

    peak_d      = peak_q;
    env_d       = env_q;
    prev_kick_d = prev_kick_q;
    mask_d      = mask_q;
    if (s1_fire) begin
      if (s1_last_q) begin
        peak_d      = '0;
        env_d       = env_new;
        prev_kick_d = kick_now;
        mask_d      = mask_new;
      end else begin
        peak_d = peak_new;
      end
    end
    if (!out_load) begin
      last_bar_d = last_bar_q;
      have_bar_d = have_bar_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q      <= '0;
      env_q       <= '0;
      prev_kick_q <= 1'b0;
      last_bar_q  <= '0;
      have_bar_q  <= 1'b0;
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      peak_q      <= peak_d;
      env_q       <= env_d;
      prev_kick_q <= prev_kick_d;
      last_bar_q  <= last_bar_d;
      have_bar_q  <= have_bar_d;
      mask_q      <= mask_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(40 - OutW)'(0), out_q};

  // ---------------- assertions ----------------
  a_env_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !env_q[skd_pkg::EnvW-1] || (env_q[skd_pkg::EnvW-2:0] == '0))
    else $error("envelope above full scale");

  a_onset_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!out_q.kick_onset || out_q.kick_present))
    else $error("onset without kick present");

  a_peak_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (peak_q == '0))
    else $error("block peak not cleared after block end");

  a_level_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_q.envelope_level == env_q[skd_pkg::EnvW-1 -: skd_pkg::PeakW]))
    else $error("held result disagrees with envelope state");

endmodule
